// File: rtl/smau_pkg.sv
// ----------------------------------------------------------------------------
// smau_pkg
// Types and constants shared by the matrix arithmetic unit.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int unsigned MaxDim    = 8;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned Depth     = MaxDim * MaxDim;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned IdxW      = 3;
  localparam int unsigned DimW      = 4;

  localparam logic [1:0] CmdLoadA = 2'd0;
  localparam logic [1:0] CmdLoadB = 2'd1;
  localparam logic [1:0] CmdRun   = 2'd2;

  localparam logic [2:0] OpMul  = 3'd0;
  localparam logic [2:0] OpAdd  = 3'd1;
  localparam logic [2:0] OpSub  = 3'd2;
  localparam logic [2:0] OpTran = 3'd3;
  localparam logic [2:0] OpSym  = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StDim   = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  localparam logic [2:0] RegOp    = 3'd0;
  localparam logic [2:0] RegRowsA = 3'd1;
  localparam logic [2:0] RegColsA = 3'd2;
  localparam logic [2:0] RegRowsB = 3'd3;
  localparam logic [2:0] RegColsB = 3'd4;

  typedef struct packed {
    logic [1:0]                  command;
    logic [IdxW-1:0]             row_index;
    logic [IdxW-1:0]             col_index;
    logic signed [DataWidth-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic [IdxW-1:0]             result_row;
    logic [IdxW-1:0]             result_col;
    logic                        test_flag;
    logic [1:0]                  status;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]      op_mode;
    logic [DimW-1:0] ra;
    logic [DimW-1:0] ca;
    logic [DimW-1:0] rb;
    logic [DimW-1:0] cb;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataWidth-1:0] wdata;
  } mem_wr_t;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxDim)) return DimW'(MaxDim);
    return v;
  endfunction

endpackage

// File: rtl/small_matrix_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_unit
// Matrix multiply / add / subtract / transpose / symmetry unit on 8x8 stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_stall_o/in_item_i) takes load-A, load-B and
//   run commands. Output channel (out_valid_o/out_stall_i/out_item_o) returns
//   result items row-major, last set on the final one of a run.
//   APB port sets op_mode and the four matrix sizes (offsets 0x0..0x10).
//   A bad load index gives one status item. A run walks the stores through
//   one read port per matrix with registered read data: add/sub/transpose
//   read, take the data and emit each element, multiply reads and accumulates
//   each term before it emits, and symmetry reads both elements of each pair.
//   Only one item is in work at a time; the input stalls during a run.
//   Reset clears control and registers (op 0, sizes 8); store contents stay
//   undefined until loaded. A stalled output holds its item and the run
//   pauses until it is taken.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  smau_pkg::in_item_t      in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output smau_pkg::out_item_t     out_item_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import smau_pkg::*;

  cfg_t cfg;
  mem_wr_t wr_a, wr_b;
  logic [AddrW-1:0] raddr_a, raddr_b;
  logic [DataWidth-1:0] rdata_a, rdata_b;

  smau_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .cfg_o(cfg)
  );

  smau_ram u_ram_a (.clk_i, .wr_i(wr_a), .raddr_i(raddr_a), .rdata_o(rdata_a));
  smau_ram u_ram_b (.clk_i, .wr_i(wr_b), .raddr_i(raddr_b), .rdata_o(rdata_b));

  smau_seq u_seq (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .wr_a_o(wr_a), .wr_b_o(wr_b),
    .raddr_a_o(raddr_a), .raddr_b_o(raddr_b),
    .rdata_a_i(rdata_a), .rdata_b_i(rdata_b)
  );

endmodule

// File: rtl/smau_ram.sv
// ----------------------------------------------------------------------------
// smau_ram
// Matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smau_ram (
  input  logic                                clk_i,
  input  smau_pkg::mem_wr_t                   wr_i,
  input  logic [smau_pkg::AddrW-1:0]          raddr_i,
  output logic [smau_pkg::DataWidth-1:0]      rdata_o
);
  import smau_pkg::*;

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr] <= wr_i.wdata;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/smau_cfg.sv
// ----------------------------------------------------------------------------
// smau_cfg
// APB register file holding operation and matrix sizes.
// ----------------------------------------------------------------------------
module smau_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output smau_pkg::cfg_t       cfg_o
);
  import smau_pkg::*;

  cfg_t cfg_q;
  logic [2:0] idx;

  assign idx   = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{op_mode: OpMul, ra: DimW'(8), ca: DimW'(8), rb: DimW'(8), cb: DimW'(8)};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegOp:    cfg_q.op_mode <= pwdata[2:0];
        RegRowsA: cfg_q.ra <= pwdata[DimW-1:0];
        RegColsA: cfg_q.ca <= pwdata[DimW-1:0];
        RegRowsB: cfg_q.rb <= pwdata[DimW-1:0];
        RegColsB: cfg_q.cb <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegOp:    prdata = {29'd0, cfg_q.op_mode};
      RegRowsA: prdata = {28'd0, cfg_q.ra};
      RegColsA: prdata = {28'd0, cfg_q.ca};
      RegRowsB: prdata = {28'd0, cfg_q.rb};
      RegColsB: prdata = {28'd0, cfg_q.cb};
      default:  prdata = '0;
    endcase
  end

endmodule

// File: rtl/smau_seq.sv
// ----------------------------------------------------------------------------
// smau_seq
// Command sequencer: stores loads, walks the stores for a run, and drives
// the output register.
// ----------------------------------------------------------------------------
module smau_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smau_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  smau_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output smau_pkg::out_item_t        out_item_o,
  output smau_pkg::mem_wr_t          wr_a_o,
  output smau_pkg::mem_wr_t          wr_b_o,
  output logic [smau_pkg::AddrW-1:0] raddr_a_o,
  output logic [smau_pkg::AddrW-1:0] raddr_b_o,
  input  logic [smau_pkg::DataWidth-1:0] rdata_a_i,
  input  logic [smau_pkg::DataWidth-1:0] rdata_b_i
);
  import smau_pkg::*;

  // RD: issue read; WT: data back; MUL: product registered; EMIT: wait output
  typedef enum logic [2:0] {S_IDLE, S_RD, S_WT, S_MUL, S_EMIT} state_e;

  state_e state_q;
  logic [IdxW-1:0] i_q, j_q, k_q;
  logic            phase_q;      // symmetry: second read of pair
  logic            sym_q;
  logic [DataWidth-1:0] acc_q, prod_q, tmp_q;
  logic [2:0]      op_q;
  logic [DimW-1:0] ra_q, ca_q, cb_q;
  out_item_t       out_q;
  logic            ovld_q;

  logic [DimW-1:0] ra, ca, rb, cb;
  logic [DimW-1:0] ld_nr, ld_nc;
  logic [2*DimW-1:0] ld_off;
  logic            ld_bad, accept, out_free;
  logic [2*DimW-1:0] off_a, off_b;
  logic            lastel, k_end;

  assign ra = sat_dim(cfg_i.ra);
  assign ca = sat_dim(cfg_i.ca);
  assign rb = sat_dim(cfg_i.rb);
  assign cb = sat_dim(cfg_i.cb);

  assign out_free   = !ovld_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = ovld_q;
  assign out_item_o  = out_q;

  assign ld_nr  = (in_item_i.command == CmdLoadA) ? ra : rb;
  assign ld_nc  = (in_item_i.command == CmdLoadA) ? ca : cb;
  assign ld_off = DimW'(in_item_i.row_index) * ld_nc + (2*DimW)'(in_item_i.col_index);
  assign ld_bad = ({1'b0, in_item_i.row_index} >= ld_nr) ||
                  ({1'b0, in_item_i.col_index} >= ld_nc);

  always_comb begin
    wr_a_o = '{we: 1'b0, waddr: ld_off[AddrW-1:0], wdata: in_item_i.data_value};
    wr_b_o = wr_a_o;
    wr_a_o.we = accept && !ld_bad && in_item_i.command == CmdLoadA;
    wr_b_o.we = accept && !ld_bad && in_item_i.command == CmdLoadB;
  end

  // read addresses per operation
  always_comb begin
    off_a = '0;
    off_b = '0;
    case (op_q)
      OpMul: begin
        off_a = DimW'(i_q) * ca_q + (2*DimW)'(k_q);
        off_b = DimW'(k_q) * cb_q + (2*DimW)'(j_q);
      end
      OpTran: off_a = DimW'(j_q) * ca_q + (2*DimW)'(i_q);
      OpSym: begin
        if (phase_q) off_a = DimW'(j_q) * ca_q + (2*DimW)'(i_q);
        else         off_a = DimW'(i_q) * ca_q + (2*DimW)'(j_q);
      end
      default: begin
        off_a = DimW'(i_q) * ca_q + (2*DimW)'(j_q);
        off_b = DimW'(i_q) * cb_q + (2*DimW)'(j_q);
      end
    endcase
  end
  assign raddr_a_o = off_a[AddrW-1:0];
  assign raddr_b_o = off_b[AddrW-1:0];

  assign k_end  = ({1'b0, k_q} == ca_q - DimW'(1));
  assign lastel = ({1'b0, i_q} == ra_q - DimW'(1)) && ({1'b0, j_q} == cb_q - DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic      set_v;
    out_item_t item_v;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      out_q   <= '0;
      acc_q <= '0; prod_q <= '0; tmp_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0;
      phase_q <= 1'b0; sym_q <= 1'b0;
      op_q <= OpMul; ra_q <= '0; ca_q <= '0; cb_q <= '0;
    end else begin
      set_v  = 1'b0;
      item_v = '0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            i_q <= '0; j_q <= '0; k_q <= '0; phase_q <= 1'b0; sym_q <= 1'b1;
            acc_q <= '0;
            op_q <= cfg_i.op_mode;
            ra_q <= ra; ca_q <= ca;
            if (in_item_i.command == CmdLoadA || in_item_i.command == CmdLoadB) begin
              if (ld_bad) begin
                item_v.status = StRange;
                item_v.last = 1'b1;
                set_v = 1'b1;
              end
            end else if (in_item_i.command == CmdRun) begin
              case (cfg_i.op_mode) inside
                OpMul: begin
                  cb_q <= cb;
                  if (ca != rb) begin
                    item_v.status = StDim; item_v.last = 1'b1; set_v = 1'b1;
                  end else state_q <= S_RD;
                end
                OpAdd, OpSub: begin
                  cb_q <= cb;
                  if (ra != rb || ca != cb) begin
                    item_v.status = StDim; item_v.last = 1'b1; set_v = 1'b1;
                  end else state_q <= S_RD;
                end
                OpTran: begin
                  cb_q <= ra;
                  if (ra != ca || ca == DimW'(1)) begin
                    item_v.status = StDim; item_v.last = 1'b1; set_v = 1'b1;
                  end else state_q <= S_RD;
                end
                OpSym: begin
                  cb_q <= ca;
                  if (ra != ca || ca == DimW'(1)) begin
                    item_v.last = 1'b1; set_v = 1'b1;
                  end else state_q <= S_RD;
                end
                default: ;
              endcase
            end
          end
        end
        S_RD: state_q <= S_WT;
        S_WT: begin
          if (op_q == OpMul) begin
            prod_q <= DataWidth'(rdata_a_i * rdata_b_i);
            state_q <= S_MUL;
          end else if (op_q == OpSym) begin
            if (!phase_q) begin
              tmp_q <= rdata_a_i; phase_q <= 1'b1; state_q <= S_RD;
            end else begin
              phase_q <= 1'b0;
              if (tmp_q != rdata_a_i) sym_q <= 1'b0;
              if (lastel || tmp_q != rdata_a_i) begin
                state_q <= S_EMIT;
              end else begin
                state_q <= S_RD;
                if ({1'b0, j_q} == cb_q - DimW'(1)) begin
                  i_q <= i_q + 1'b1; j_q <= i_q + 1'b1;
                end else j_q <= j_q + 1'b1;
              end
            end
          end else begin
            if (op_q == OpAdd)      acc_q <= rdata_a_i + rdata_b_i;
            else if (op_q == OpSub) acc_q <= rdata_a_i - rdata_b_i;
            else                    acc_q <= rdata_a_i;
            state_q <= S_EMIT;
          end
        end
        S_MUL: begin
          acc_q <= acc_q + prod_q;
          if (k_end) state_q <= S_EMIT;
          else begin
            k_q <= k_q + 1'b1; state_q <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            set_v = 1'b1;
            if (op_q == OpSym) begin
              item_v.test_flag = sym_q;
              item_v.last = 1'b1;
              state_q <= S_IDLE;
            end else begin
              item_v.result_value = acc_q;
              item_v.result_row = i_q;
              item_v.result_col = j_q;
              item_v.last = lastel;
              acc_q <= '0; k_q <= '0;
              if (lastel) state_q <= S_IDLE;
              else begin
                state_q <= S_RD;
                if ({1'b0, j_q} == cb_q - DimW'(1)) begin
                  j_q <= '0; i_q <= i_q + 1'b1;
                end else j_q <= j_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (set_v) begin
        ovld_q <= 1'b1;
        out_q  <= item_v;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/smau_checker.sv
// ----------------------------------------------------------------------------
// smau_checker
// Port-level checks for the matrix arithmetic unit.
// ----------------------------------------------------------------------------
module smau_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input smau_pkg::out_item_t out_item_o
);
  import smau_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed under stall");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != StOk |-> out_item_o.last)
    else $error("status item without last");

  a_flag_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.test_flag |-> out_item_o.last &&
    out_item_o.status == StOk)
    else $error("flag item malformed");

  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind small_matrix_arithmetic_unit smau_checker u_smau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_item_o
);

// File: tb/sv/tb_small_matrix_arithmetic_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_small_matrix_arithmetic_unit
// Loads A and B through the item port, sets sizes and op over APB, runs every
// op and checks each result item against a local matrix predictor, under
// random input gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_small_matrix_arithmetic_unit;
  import smau_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  small_matrix_arithmetic_unit u_dut (.*);

  // predictor state
  logic [31:0]     mat_a [Depth];
  logic [31:0]     mat_b [Depth];
  bit              a_written [Depth];
  bit              b_written [Depth];
  logic [2:0]      cur_op;
  logic [DimW-1:0] cur_ra, cur_ca, cur_rb, cur_cb;
  out_item_t       pending_results[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned burst_left;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned sat(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return 32'(v);
  endfunction

  function automatic out_item_t mk(logic [31:0] v, int unsigned r, int unsigned c,
                                   bit flag, logic [1:0] st, bit lst);
    out_item_t o;
    o.result_value = v;
    o.result_row   = r[2:0];
    o.result_col   = c[2:0];
    o.test_flag    = flag;
    o.status       = st;
    o.last         = lst;
    return o;
  endfunction

  function automatic void compute_matrix_results(in_item_t it);
    int unsigned ra, ca, rb, cb, nr, nc, off;
    logic [31:0] acc;
    bit sym;
    ra = sat(cur_ra); ca = sat(cur_ca); rb = sat(cur_rb); cb = sat(cur_cb);
    if (it.command == CmdLoadA || it.command == CmdLoadB) begin
      nr  = (it.command == CmdLoadA) ? ra : rb;
      nc  = (it.command == CmdLoadA) ? ca : cb;
      off = it.row_index * nc + it.col_index;
      if (it.row_index >= nr || it.col_index >= nc || off >= Depth) begin
        pending_results.push_back(mk('0, 0, 0, 0, StRange, 1));
      end else if (it.command == CmdLoadA) begin
        mat_a[off] = it.data_value; a_written[off] = 1;
      end else begin
        mat_b[off] = it.data_value; b_written[off] = 1;
      end
      return;
    end
    if (it.command != CmdRun) return;
    case (cur_op) inside
      OpMul: begin
        if (ca != rb) pending_results.push_back(mk('0, 0, 0, 0, StDim, 1));
        else
          for (int i = 0; i < ra; i++)
            for (int j = 0; j < cb; j++) begin
              acc = '0;
              for (int k = 0; k < ca; k++) acc += mat_a[i*ca+k] * mat_b[k*cb+j];
              pending_results.push_back(mk(acc, i, j, 0, StOk, i == ra-1 && j == cb-1));
            end
      end
      OpAdd, OpSub: begin
        if (ra != rb || ca != cb) pending_results.push_back(mk('0, 0, 0, 0, StDim, 1));
        else
          for (int i = 0; i < ra; i++)
            for (int j = 0; j < ca; j++) begin
              acc = (cur_op == OpAdd) ? mat_a[i*ca+j] + mat_b[i*cb+j]
                                      : mat_a[i*ca+j] - mat_b[i*cb+j];
              pending_results.push_back(mk(acc, i, j, 0, StOk, i == ra-1 && j == ca-1));
            end
      end
      OpTran: begin
        if (ra != ca || ca == 1) pending_results.push_back(mk('0, 0, 0, 0, StDim, 1));
        else
          for (int i = 0; i < ca; i++)
            for (int j = 0; j < ra; j++)
              pending_results.push_back(mk(mat_a[j*ca+i], i, j, 0, StOk,
                                           i == ca-1 && j == ra-1));
      end
      OpSym: begin
        sym = (ra == ca) && (ca != 1);
        if (sym)
          for (int i = 0; i < ra; i++)
            for (int j = i; j < ca; j++)
              if (mat_a[i*ca+j] != mat_a[j*ca+i]) sym = 0;
        pending_results.push_back(mk('0, 0, 0, sym, StOk, 1));
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item %p", $time, out_item_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_item_o.result_value !== e.result_value)
          $display("%0t: value exp %0d got %0d", $time, e.result_value,
                   out_item_o.result_value);
        if (out_item_o.result_row !== e.result_row)
          $display("%0t: row exp %0d got %0d", $time, e.result_row, out_item_o.result_row);
        if (out_item_o.result_col !== e.result_col)
          $display("%0t: col exp %0d got %0d", $time, e.result_col, out_item_o.result_col);
        if (out_item_o.test_flag !== e.test_flag)
          $display("%0t: flag exp %0d got %0d", $time, e.test_flag, out_item_o.test_flag);
        if (out_item_o.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_item_o.status);
        if (out_item_o.last !== e.last)
          $display("%0t: last exp %0d got %0d", $time, e.last, out_item_o.last);
        if (out_item_o !== e) errors++;
      end
    end
  end

  // output stall pattern, plus one long hold-off on request
  initial begin
    int unsigned mode, left, hold_left;
    bit hold_done;
    out_stall_i = 1'b0;
    mode = 0; left = 0; hold_left = 0; hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1; hold_left = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(3); left = $urandom_range(100, 20);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3) == 0);
        2: out_stall_i <= ($urandom_range(9) < 7);
        default: out_stall_i <= (cycles % 3 == 0);
      endcase
    end
  end

  task automatic send_item(logic [1:0] cmd, int unsigned r, int unsigned c,
                           logic [31:0] v);
    in_item_t it;
    it.command = cmd; it.row_index = r[2:0]; it.col_index = c[2:0]; it.data_value = v;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compute_matrix_results(it);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end else burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegOp:    cur_op = v[2:0];
      RegRowsA: cur_ra = v[3:0];
      RegColsA: cur_ca = v[3:0];
      RegRowsB: cur_rb = v[3:0];
      RegColsB: cur_cb = v[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [2:0] op, int unsigned ra, int unsigned ca,
                            int unsigned rb, int unsigned cb);
    drain();
    apb_write(RegOp, {29'd0, op});
    apb_write(RegRowsA, ra);
    apb_write(RegColsA, ca);
    apb_write(RegRowsB, rb);
    apb_write(RegColsB, cb);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // load every element of the configured size, or only those not yet written; symmetric A when asked
  task automatic fill_matrices(bit symmetric, bit only_missing);
    int unsigned ra, ca, rb, cb;
    logic [31:0] v;
    ra = sat(cur_ra); ca = sat(cur_ca); rb = sat(cur_rb); cb = sat(cur_cb);
    for (int i = 0; i < ra; i++)
      for (int j = 0; j < ca; j++)
        if (!only_missing || !a_written[i*ca+j]) begin
          v = rand_value();
          if (symmetric && ra == ca && j < i) v = mat_a[j*ca+i];
          send_item(CmdLoadA, i, j, v);
        end
    for (int i = 0; i < rb; i++)
      for (int j = 0; j < cb; j++)
        if (!only_missing || !b_written[i*cb+j]) send_item(CmdLoadB, i, j, rand_value());
  endtask

  task automatic test_extremes();
    set_config(OpAdd, 3, 3, 3, 3);
    send_item(CmdLoadA, 0, 0, 32'h8000_0000);
    send_item(CmdLoadA, 2, 2, 32'h7fff_ffff);
    send_item(CmdLoadB, 2, 2, 32'hffff_ffff);
    fill_matrices(0, 1);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpSub, 3, 3, 3, 3);
    send_item(CmdRun, 7, 7, 32'hffff_ffff);
    set_config(OpMul, 3, 3, 3, 3);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpTran, 3, 3, 3, 3);
    send_item(CmdRun, 0, 0, 0);
  endtask

  task automatic test_special_cases();
    set_config(OpMul, 2, 3, 2, 3);
    send_item(CmdLoadA, 2, 0, 1);
    send_item(CmdLoadA, 0, 3, 1);
    send_item(CmdLoadB, 7, 7, 1);
    send_item(2'd3, 7, 7, 32'hffff_ffff);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpAdd, 2, 3, 3, 2);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpTran, 2, 3, 2, 3);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpTran, 0, 0, 1, 1);
    fill_matrices(0, 1);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpSym, 1, 1, 1, 1);
    send_item(CmdRun, 0, 0, 0);
    set_config(OpSym, 2, 3, 1, 1);
    send_item(CmdRun, 0, 0, 0);
    set_config(3'd5, 15, 15, 15, 15);
    send_item(CmdRun, 0, 0, 0);
    set_config(3'd7, 15, 15, 0, 0);
    send_item(CmdRun, 0, 0, 0);
  endtask

  task automatic test_symmetry();
    set_config(OpSym, 4, 4, 4, 4);
    fill_matrices(1, 0);
    send_item(CmdRun, 0, 0, 0);
    send_item(CmdLoadA, 0, 3, rand_value() ^ mat_a[12]);
    send_item(CmdRun, 0, 0, 0);
  endtask

  task automatic test_back_pressure();
    set_config(OpMul, 3, 3, 3, 3);
    fill_matrices(0, 1);
    drain();
    hold_req = 1'b1;
    send_item(CmdRun, 0, 0, 0);
    send_item(CmdLoadA, 1, 1, rand_value());
    send_item(CmdRun, 0, 0, 0);
    send_item(CmdLoadB, 2, 0, rand_value());
    send_item(CmdRun, 0, 0, 0);
    hold_req = 1'b0;
  endtask

  task automatic test_random();
    int unsigned start, ra, ca, rb, cb, pick;
    logic [2:0] op;
    start = items_sent;
    while (items_sent - start < 50) begin
      pick = $urandom_range(19);
      op   = (pick == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      ra = $urandom_range(4, 1); ca = $urandom_range(4, 1);
      if (pick == 1) begin ra = 8; ca = $urandom_range(8, 1); end
      if (pick == 2) ra = 0;
      if (pick == 3) ca = 15;
      rb = $urandom_range(4, 1); cb = $urandom_range(4, 1);
      if ($urandom_range(4) != 0) begin
        case (op) inside
          OpMul: rb = ca;
          OpAdd, OpSub: begin rb = ra; cb = ca; end
          OpTran, OpSym: ca = ra;
          default: ;
        endcase
      end
      set_config(op, ra, ca, rb, cb);
      fill_matrices(op == OpSym && $urandom_range(1), $urandom_range(3) == 0);
      repeat ($urandom_range(2)) begin
        case ($urandom_range(2))
          0: send_item(2'($urandom_range(1)), $urandom_range(7), $urandom_range(7),
                       $urandom);
          1: send_item(2'd3, $urandom_range(7), $urandom_range(7), $urandom);
          default: ;
        endcase
      end
      fill_matrices(0, 1);
      repeat ($urandom_range(2, 1)) send_item(CmdRun, $urandom_range(7),
                                               $urandom_range(7), $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_req = 1'b0;
    errors = 0; cycles = 0; items_sent = 0; burst_left = 0;
    cur_op = OpMul; cur_ra = 8; cur_ca = 8; cur_rb = 8; cur_cb = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_symmetry();
    test_back_pressure();
    test_random();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
